FILE: hw/rtl/bpd_pkg.sv
// ---------------------------------------------------------------------------
// bpd_pkg
// Shared types, register codes and helpers for the button press duration
// event block.
// ---------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

    localparam int unsigned MaxButtons  = 4;
    localparam int unsigned MaxEncoders = 4;

    // event bit positions
    localparam int unsigned EvDown  = 0;
    localparam int unsigned EvUp    = 1;
    localparam int unsigned EvTap   = 2;
    localparam int unsigned EvHold  = 3;
    localparam int unsigned EvLong  = 4;
    localparam int unsigned EvVlong = 5;

    // crossed-mark bit positions
    localparam int unsigned MarkHold  = 0;
    localparam int unsigned MarkLong  = 1;
    localparam int unsigned MarkVlong = 2;

    localparam logic [31:0] DebounceReset = 32'd20000;
    localparam logic [31:0] HoldReset     = 32'd300000;
    localparam logic [31:0] LongReset     = 32'd1000000;
    localparam logic [31:0] VlongReset    = 32'd3000000;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_HOLD     = 2'd1,
        CFG_LONG     = 2'd2,
        CFG_VLONG    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] debounce_us;
        logic [31:0] hold_us;
        logic [31:0] long_us;
        logic [31:0] very_long_us;
    } t_thresholds;

    typedef struct packed {
        logic        en;
        logic        drain;
        logic [15:0] tick_us;
    } t_step_ctl;

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bpd_cfg.sv
// ---------------------------------------------------------------------------
// bpd_cfg
// APB-style register file holding the four press time thresholds.
// ---------------------------------------------------------------------------
`default_nettype none

module bpd_cfg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bpd_pkg::t_thresholds o_thr
);

    bpd_pkg::t_thresholds r_thr;
    bpd_pkg::t_cfg_idx    idx;

    assign idx    = bpd_pkg::t_cfg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_thr  = r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.debounce_us  <= bpd_pkg::DebounceReset;
            r_thr.hold_us      <= bpd_pkg::HoldReset;
            r_thr.long_us      <= bpd_pkg::LongReset;
            r_thr.very_long_us <= bpd_pkg::VlongReset;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                bpd_pkg::CFG_DEBOUNCE: r_thr.debounce_us  <= pwdata;
                bpd_pkg::CFG_HOLD:     r_thr.hold_us      <= pwdata;
                bpd_pkg::CFG_LONG:     r_thr.long_us      <= pwdata;
                bpd_pkg::CFG_VLONG:    r_thr.very_long_us <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bpd_pkg::CFG_DEBOUNCE: prdata = r_thr.debounce_us;
            bpd_pkg::CFG_HOLD:     prdata = r_thr.hold_us;
            bpd_pkg::CFG_LONG:     prdata = r_thr.long_us;
            bpd_pkg::CFG_VLONG:    prdata = r_thr.very_long_us;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bpd_button.sv
// ---------------------------------------------------------------------------
// bpd_button
// Per-button tracker: level, held time, crossed thresholds and sticky
// event bits. Gives the event snapshot for the item in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module bpd_button (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bpd_pkg::t_step_ctl   i_ctl,
    input  wire                  i_level,
    input  bpd_pkg::t_thresholds i_thr,
    output logic [5:0]           o_snap
);

    logic        r_level;
    logic [31:0] r_held;
    logic [2:0]  r_marks;
    logic [5:0]  r_events;

    logic        n_level;
    logic [31:0] n_held;
    logic [2:0]  n_marks;
    logic [5:0]  n_events;
    logic [31:0] held_sum;

    assign held_sum = bpd_pkg::sat_add32(r_held, i_ctl.tick_us);

    always_comb begin
        n_level  = r_level;
        n_held   = r_held;
        n_marks  = r_marks;
        n_events = r_events;
        if (i_ctl.drain) begin
            n_events = 6'd0;
        end else if (i_level && !r_level) begin
            // press edge: restart the hold timer, this tick is not counted
            n_events[bpd_pkg::EvDown] = 1'b1;
            n_held  = 32'd0;
            n_marks = 3'd0;
            n_level = 1'b1;
        end else if (i_level) begin
            n_held = held_sum;
            if (!r_marks[bpd_pkg::MarkHold] && held_sum >= i_thr.hold_us) begin
                n_events[bpd_pkg::EvHold] = 1'b1;
                n_marks[bpd_pkg::MarkHold] = 1'b1;
            end
            if (!r_marks[bpd_pkg::MarkLong] && held_sum >= i_thr.long_us) begin
                n_events[bpd_pkg::EvLong] = 1'b1;
                n_marks[bpd_pkg::MarkLong] = 1'b1;
            end
            if (!r_marks[bpd_pkg::MarkVlong] && held_sum >= i_thr.very_long_us) begin
                n_events[bpd_pkg::EvVlong] = 1'b1;
                n_marks[bpd_pkg::MarkVlong] = 1'b1;
            end
        end else if (r_level) begin
            // release: the release tick still counts toward the press time
            n_held  = held_sum;
            n_level = 1'b0;
            if (held_sum >= i_thr.debounce_us) begin
                n_events[bpd_pkg::EvUp] = 1'b1;
                if (held_sum < i_thr.hold_us) begin
                    n_events[bpd_pkg::EvTap] = 1'b1;
                end
            end
        end
        // a drain reports the events before clearing
        o_snap = i_ctl.drain ? r_events : n_events;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 1'b0;
            r_held   <= 32'd0;
            r_marks  <= 3'd0;
            r_events <= 6'd0;
        end else if (i_ctl.en) begin
            r_level  <= n_level;
            r_held   <= n_held;
            r_marks  <= n_marks;
            r_events <= n_events;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bpd_accum.sv
// ---------------------------------------------------------------------------
// bpd_accum
// Saturating accumulators for elapsed tick time and encoder movement.
// ---------------------------------------------------------------------------
`default_nettype none

module bpd_accum #(
    parameter int unsigned NUM_ENCODERS = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bpd_pkg::t_step_ctl i_ctl,
    input  wire  [3:0][7:0]    i_steps,
    output logic [31:0]        o_elapsed,
    output logic [3:0][15:0]   o_totals
);

    logic [31:0] r_elapsed;
    logic [31:0] n_elapsed;

    always_comb begin
        n_elapsed = i_ctl.drain ? 32'd0 : bpd_pkg::sat_add32(r_elapsed, i_ctl.tick_us);
        o_elapsed = i_ctl.drain ? r_elapsed : n_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= 32'd0;
        end else if (i_ctl.en) begin
            r_elapsed <= n_elapsed;
        end
    end

    for (genvar e = 0; e < bpd_pkg::MaxEncoders; e++) begin : g_enc
        if (e < NUM_ENCODERS) begin : g_used
            logic [15:0] r_sum;
            logic [15:0] n_sum;
            logic [16:0] wide;

            assign wide = {r_sum[15], r_sum} + {{9{i_steps[e][7]}}, i_steps[e]};

            always_comb begin
                if (i_ctl.drain) begin
                    n_sum = 16'd0;
                end else if (wide[16] != wide[15]) begin
                    // clamp on overflow in either direction
                    n_sum = wide[16] ? 16'h8000 : 16'h7FFF;
                end else begin
                    n_sum = wide[15:0];
                end
            end

            assign o_totals[e] = i_ctl.drain ? r_sum : n_sum;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sum <= 16'd0;
                end else if (i_ctl.en) begin
                    r_sum <= n_sum;
                end
            end
        end else begin : g_unused
            assign o_totals[e] = 16'd0;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/button_press_duration_events.sv
// ---------------------------------------------------------------------------
// button_press_duration_events
// Button press duration events with saturating time and encoder totals.
//
// Input channel (i_in_valid / o_in_stall): one beat is a tick (i_action 0)
// with elapsed microseconds, button levels and encoder steps, or a drain
// (i_action 1) that reports and clears the sticky events and totals.
// Output channel (o_out_valid / i_out_stall): one snapshot beat per input
// beat, in order. A tick shows values after its update, a drain shows the
// values before clearing.
// An input beat is captured in the input register, then the per-button and
// accumulator update writes it into the output register.
// Throughput: one beat per cycle while the output is not stalled, set by the
// combinational update of the 32-bit held-time adders and threshold compares.
// Stall: while the output register holds an untaken beat and i_out_stall is
// high, the item in the input register waits and o_in_stall rises.
// Reset clears all button state, totals and events, empties both registers
// and loads the threshold registers with their defaults. The user must write
// thresholds over the APB-style port while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_duration_events #(
    parameter int unsigned NUM_BUTTONS  = 4,
    parameter int unsigned NUM_ENCODERS = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_action,
    input  wire  [15:0]        i_tick_us,
    input  wire  [3:0]         i_buttons_down,
    input  wire  signed [7:0]  i_enc0_step,
    input  wire  signed [7:0]  i_enc1_step,
    input  wire  signed [7:0]  i_enc2_step,
    input  wire  signed [7:0]  i_enc3_step,
    // output channel
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [31:0]        o_elapsed_us,
    output logic [5:0]         o_btn0_events,
    output logic [5:0]         o_btn1_events,
    output logic [5:0]         o_btn2_events,
    output logic [5:0]         o_btn3_events,
    output logic signed [15:0] o_enc0_total,
    output logic signed [15:0] o_enc1_total,
    output logic signed [15:0] o_enc2_total,
    output logic signed [15:0] o_enc3_total
);

    bpd_pkg::t_thresholds thr;
    bpd_pkg::t_step_ctl   ctl;

    logic               r_in_valid;
    logic               r_action;
    logic [15:0]        r_tick_us;
    logic [3:0]         r_buttons;
    logic [3:0][7:0]    r_steps;

    logic               r_out_valid;
    logic [31:0]        r_elapsed;
    logic [3:0][5:0]    r_events;
    logic [3:0][15:0]   r_totals;

    logic               advance;
    logic [31:0]        snap_elapsed;
    logic [3:0][5:0]    snap_events;
    logic [3:0][15:0]   snap_totals;

    bpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (thr)
    );

    // move the held item forward whenever the output register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign ctl.en      = advance;
    assign ctl.drain   = r_action;
    assign ctl.tick_us = r_tick_us;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action  <= i_action;
            r_tick_us <= i_tick_us;
            r_buttons <= i_buttons_down;
            r_steps   <= {i_enc3_step, i_enc2_step, i_enc1_step, i_enc0_step};
        end
    end

    for (genvar b = 0; b < bpd_pkg::MaxButtons; b++) begin : g_btn
        if (b < NUM_BUTTONS) begin : g_used
            bpd_button u_button (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_level (r_buttons[b]),
                .i_thr   (thr),
                .o_snap  (snap_events[b])
            );
        end else begin : g_unused
            assign snap_events[b] = 6'd0;
        end
    end

    bpd_accum #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_steps   (r_steps),
        .o_elapsed (snap_elapsed),
        .o_totals  (snap_totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_elapsed <= snap_elapsed;
            r_events  <= snap_events;
            r_totals  <= snap_totals;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_elapsed_us  = r_elapsed;
    assign o_btn0_events = r_events[0];
    assign o_btn1_events = r_events[1];
    assign o_btn2_events = r_events[2];
    assign o_btn3_events = r_events[3];
    assign o_enc0_total  = r_totals[0];
    assign o_enc1_total  = r_totals[1];
    assign o_enc2_total  = r_totals[2];
    assign o_enc3_total  = r_totals[3];

endmodule

`default_nettype wire

FILE: hw/rtl/bpd_checker.sv
// ---------------------------------------------------------------------------
// bpd_checker
// Port-level checks for the button press duration event block.
// ---------------------------------------------------------------------------
`default_nettype none

module bpd_checker #(
    parameter int unsigned NUM_BUTTONS  = 4,
    parameter int unsigned NUM_ENCODERS = 4
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [31:0] o_elapsed_us,
    input wire [5:0]  o_btn0_events,
    input wire [5:0]  o_btn1_events,
    input wire [5:0]  o_btn2_events,
    input wire [5:0]  o_btn3_events,
    input wire [15:0] o_enc0_total,
    input wire [15:0] o_enc1_total,
    input wire [15:0] o_enc2_total,
    input wire [15:0] o_enc3_total
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input back-pressure only comes from a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_elapsed_us) && $stable(o_btn0_events)
             && $stable(o_enc0_total)))
        else $error("stalled result changed");

    // slots beyond the configured counts read zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((NUM_BUTTONS > 1 || o_btn1_events == 6'd0)
             && (NUM_BUTTONS > 2 || o_btn2_events == 6'd0)
             && (NUM_BUTTONS > 3 || o_btn3_events == 6'd0)
             && (NUM_ENCODERS > 1 || o_enc1_total == 16'd0)
             && (NUM_ENCODERS > 2 || o_enc2_total == 16'd0)
             && (NUM_ENCODERS > 3 || o_enc3_total == 16'd0)))
        else $error("unused slot not zero");

endmodule

bind button_press_duration_events bpd_checker #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .NUM_ENCODERS (NUM_ENCODERS)
) u_bpd_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for button_press_duration_events.
//
// Tick and drain beats go in over the valid/stall input channel. A local
// copy of the per-button timing state, the sticky events and the saturating
// totals predicts one snapshot per beat. Every snapshot beat on the output
// channel is compared with the oldest prediction. A short table opens the
// run. A long press then drives encoder totals 0 and 1 into saturation.
// Random phases with fresh thresholds follow, with sender gaps and receiver
// stalls that change from phase to phase.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic            drain;
        logic [15:0]     tick_us;
        logic [3:0]      buttons;
        logic [3:0][7:0] steps;
    } t_beat;

    typedef struct packed {
        logic [31:0]      elapsed;
        logic [3:0][5:0]  events;
        logic [3:0][15:0] totals;
    } t_snap;

    typedef struct packed {
        t_row_kind           kind;
        bpd_pkg::t_cfg_idx   reg_idx;
        logic [31:0]         reg_val;
        t_beat               beat;
        logic                typed;
        t_snap               snap;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = 1'b0;
    logic [15:0]        i_tick_us = '0;
    logic [3:0]         i_buttons_down = '0;
    logic signed [7:0]  i_enc0_step = '0;
    logic signed [7:0]  i_enc1_step = '0;
    logic signed [7:0]  i_enc2_step = '0;
    logic signed [7:0]  i_enc3_step = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [31:0]        o_elapsed_us;
    logic [5:0]         o_btn0_events;
    logic [5:0]         o_btn1_events;
    logic [5:0]         o_btn2_events;
    logic [5:0]         o_btn3_events;
    logic signed [15:0] o_enc0_total;
    logic signed [15:0] o_enc1_total;
    logic signed [15:0] o_enc2_total;
    logic signed [15:0] o_enc3_total;

    // predicted block state
    logic [31:0]        thr [4];
    logic [3:0]         lvl = '0;
    logic [31:0]        held_us [4] = '{default: '0};
    logic [2:0]         crossed [4] = '{default: '0};
    logic [5:0]         latched_ev [4] = '{default: '0};
    logic [31:0]        elapsed_acc = '0;
    logic signed [15:0] enc_sum [4] = '{default: '0};

    t_snap       expected_snaps [$];
    int unsigned send_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;

    button_press_duration_events dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_tick_us      (i_tick_us),
        .i_buttons_down (i_buttons_down),
        .i_enc0_step    (i_enc0_step),
        .i_enc1_step    (i_enc1_step),
        .i_enc2_step    (i_enc2_step),
        .i_enc3_step    (i_enc3_step),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_elapsed_us   (o_elapsed_us),
        .o_btn0_events  (o_btn0_events),
        .o_btn1_events  (o_btn1_events),
        .o_btn2_events  (o_btn2_events),
        .o_btn3_events  (o_btn3_events),
        .o_enc0_total   (o_enc0_total),
        .o_enc1_total   (o_enc1_total),
        .o_enc2_total   (o_enc2_total),
        .o_enc3_total   (o_enc3_total)
    );

    initial begin : clock_gen
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
        return (a > 32'hFFFF_FFFF - 32'(b)) ? 32'hFFFF_FFFF : a + 32'(b);
    endfunction

    function automatic t_snap current_snap();
        t_snap s;
        s.elapsed = elapsed_acc;
        for (int i = 0; i < 4; i++) begin
            s.events[i] = latched_ev[i];
            s.totals[i] = enc_sum[i];
        end
        return s;
    endfunction

    function automatic void cross_mark(int b, int mark, int ev, logic [31:0] limit);
        if (!crossed[b][mark] && held_us[b] >= limit) begin
            crossed[b][mark] = 1'b1;
            latched_ev[b][ev] = 1'b1;
        end
    endfunction

    function automatic t_snap next_snapshot(t_beat bt);
        t_snap s;
        int    sum;
        if (bt.drain) begin
            // report first, then clear
            s = current_snap();
            elapsed_acc = '0;
            for (int i = 0; i < 4; i++) begin
                latched_ev[i] = '0;
                enc_sum[i] = '0;
            end
            return s;
        end
        elapsed_acc = add_sat(elapsed_acc, bt.tick_us);
        for (int b = 0; b < 4; b++) begin
            if (bt.buttons[b] && !lvl[b]) begin
                // press edge: restart timing, test no threshold
                latched_ev[b][bpd_pkg::EvDown] = 1'b1;
                held_us[b] = '0;
                crossed[b] = '0;
            end else if (bt.buttons[b]) begin
                held_us[b] = add_sat(held_us[b], bt.tick_us);
                cross_mark(b, bpd_pkg::MarkHold, bpd_pkg::EvHold, thr[bpd_pkg::CFG_HOLD]);
                cross_mark(b, bpd_pkg::MarkLong, bpd_pkg::EvLong, thr[bpd_pkg::CFG_LONG]);
                cross_mark(b, bpd_pkg::MarkVlong, bpd_pkg::EvVlong,
                           thr[bpd_pkg::CFG_VLONG]);
            end else if (lvl[b]) begin
                held_us[b] = add_sat(held_us[b], bt.tick_us);
                if (held_us[b] >= thr[bpd_pkg::CFG_DEBOUNCE]) begin
                    latched_ev[b][bpd_pkg::EvUp] = 1'b1;
                    if (held_us[b] < thr[bpd_pkg::CFG_HOLD])
                        latched_ev[b][bpd_pkg::EvTap] = 1'b1;
                end
            end
        end
        lvl = bt.buttons;
        for (int e = 0; e < 4; e++) begin
            sum = int'(enc_sum[e]) + int'($signed(bt.steps[e]));
            if (sum > 32767)
                sum = 32767;
            if (sum < -32768)
                sum = -32768;
            enc_sum[e] = 16'(sum);
        end
        return current_snap();
    endfunction

    function automatic void set_idle(t_idle mode);
        case (mode)
            IDLE_NONE: begin
                send_pct = 0;
                stall_pct = 0;
            end
            IDLE_SEND: begin
                send_pct = 62;
                stall_pct = 0;
            end
            IDLE_RECV: begin
                send_pct = 0;
                stall_pct = 62;
            end
            default: begin
                send_pct = 19;
                stall_pct = 19;
            end
        endcase
    endfunction

    function automatic t_row beat_row(logic drain, logic [15:0] tick, logic [3:0] btn,
                                      logic [31:0] steps);
        t_row r;
        r = '0;
        r.kind = ROW_BEAT;
        r.beat.drain = drain;
        r.beat.tick_us = tick;
        r.beat.buttons = btn;
        r.beat.steps = steps;
        return r;
    endfunction

    function automatic t_row cfg_row(bpd_pkg::t_cfg_idx idx, logic [31:0] val);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, logic [31:0] el, logic [23:0] ev,
                                       logic [63:0] tot);
        t_row t;
        t = r;
        t.typed = 1'b1;
        t.snap.elapsed = el;
        t.snap.events = ev;
        t.snap.totals = tot;
        return t;
    endfunction

    task automatic write_threshold(bpd_pkg::t_cfg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thr[idx] = val;
        @(posedge i_clk);
    endtask

    // hold the input side until every predicted snapshot has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_snaps.size() != 0);
    endtask

    task automatic send_beat(t_beat bt, logic typed, t_snap typed_snap);
        t_snap s;
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= bt.drain;
        i_tick_us <= bt.tick_us;
        i_buttons_down <= bt.buttons;
        i_enc0_step <= bt.steps[0];
        i_enc1_step <= bt.steps[1];
        i_enc2_step <= bt.steps[2];
        i_enc3_step <= bt.steps[3];
        s = next_snapshot(bt);
        expected_snaps.push_back(typed ? typed_snap : s);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin : snapshot_check
        t_snap got;
        t_snap want;
        logic  bad;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.elapsed = o_elapsed_us;
                got.events = {o_btn3_events, o_btn2_events, o_btn1_events, o_btn0_events};
                got.totals = {o_enc3_total, o_enc2_total, o_enc1_total, o_enc0_total};
                if (expected_snaps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected snapshot beat: el %0d ev %h tot %h",
                                 got.elapsed, got.events, got.totals);
                end else begin
                    want = expected_snaps.pop_front();
                    bad = (got.elapsed !== want.elapsed);
                    for (int i = 0; i < 4; i++)
                        bad |= (got.events[i] !== want.events[i]) ||
                               (got.totals[i] !== want.totals[i]);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("snapshot: want el %0d ev %h tot %h, got el %0d ev %h tot %h",
                                     want.elapsed, want.events, want.totals,
                                     got.elapsed, got.events, got.totals);
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin : watchdog
        #(40_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_row        rows [$];
        t_row        row;
        t_beat       bt;
        logic [31:0] new_thr [4];
        logic [15:0] tick_max;
        int unsigned drain_div;
        int unsigned toggle_div;
        logic [1:0]  bias [4];
        logic [3:0]  btn_state;

        thr = '{bpd_pkg::DebounceReset, bpd_pkg::HoldReset, bpd_pkg::LongReset,
                bpd_pkg::VlongReset};
        set_idle(IDLE_BOTH);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            // drain right after reset ignores its tick, levels and steps
            typed_row(beat_row(1'b1, 16'hFFFF, 4'hF, 32'h7F80_FF01), 0, '0, '0),
            typed_row(beat_row(1'b0, 16'h0000, 4'h0, 32'h0), 0, '0, '0),
            typed_row(beat_row(1'b0, 16'hFFFF, 4'h0, 32'h01FF_807F), 65535, '0,
                      {16'h0001, 16'hFFFF, 16'hFF80, 16'h007F}),
            // press tick does not count its time
            typed_row(beat_row(1'b0, 16'd100, 4'hF, 32'h0), 65635, {4{6'h01}},
                      {16'h0001, 16'hFFFF, 16'hFF80, 16'h007F}),
            typed_row(beat_row(1'b1, 16'd0, 4'h0, 32'h0), 65635, {4{6'h01}},
                      {16'h0001, 16'hFFFF, 16'hFF80, 16'h007F}),
            typed_row(beat_row(1'b0, 16'hFFFF, 4'hF, 32'h0), 65535, '0, '0),
            typed_row(beat_row(1'b0, 16'd0, 4'h0, 32'h0), 65535, {4{6'h06}}, '0),
            cfg_row(bpd_pkg::CFG_DEBOUNCE, 32'd1000),
            cfg_row(bpd_pkg::CFG_HOLD, 32'd2000),
            cfg_row(bpd_pkg::CFG_LONG, 32'd3000),
            cfg_row(bpd_pkg::CFG_VLONG, 32'd4000),
            beat_row(1'b0, 16'd0, 4'b0001, 32'h0),
            beat_row(1'b0, 16'd500, 4'b0011, 32'h0),
            beat_row(1'b0, 16'd500, 4'b0010, 32'h0),
            beat_row(1'b0, 16'd1500, 4'b0010, 32'h0),
            beat_row(1'b0, 16'd1000, 4'b0010, 32'h0),
            beat_row(1'b0, 16'd1000, 4'b0110, 32'h0),
            beat_row(1'b0, 16'd999, 4'b1000, 32'h0),
            beat_row(1'b0, 16'hFFFF, 4'b1000, 32'h8080_8080),
            beat_row(1'b0, 16'd0, 4'b0000, 32'h0),
            beat_row(1'b1, 16'd0, 4'b0000, 32'h0),
            cfg_row(bpd_pkg::CFG_DEBOUNCE, 32'd0),
            cfg_row(bpd_pkg::CFG_HOLD, 32'd0),
            cfg_row(bpd_pkg::CFG_LONG, 32'd0),
            cfg_row(bpd_pkg::CFG_VLONG, 32'd0),
            beat_row(1'b0, 16'd0, 4'hF, 32'h0),
            beat_row(1'b0, 16'd0, 4'hF, 32'h0),
            beat_row(1'b0, 16'd0, 4'h0, 32'h0),
            typed_row(beat_row(1'b1, 16'd0, 4'h0, 32'h0), 0, {4{6'h3B}}, '0)
        };
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                settle();
                write_threshold(rows[r].reg_idx, rows[r].reg_val);
            end else begin
                send_beat(rows[r].beat, rows[r].typed, rows[r].snap);
            end
        end

        // one long press: encoder totals 0 and 1 saturate
        settle();
        for (int k = 0; k < 4; k++)
            write_threshold(bpd_pkg::t_cfg_idx'(k), 32'hFFFF_FFFF);
        set_idle(IDLE_NONE);
        row = beat_row(1'b1, 16'd0, 4'h0, 32'h0);
        send_beat(row.beat, 1'b0, '0);
        row = beat_row(1'b0, 16'd0, 4'b0101, 32'h0);
        send_beat(row.beat, 1'b0, '0);
        repeat (280) begin
            row = beat_row(1'b0, 16'hFFFF, 4'b0101, 32'h0);
            bt = row.beat;
            bt.steps = {8'($urandom()), 8'($urandom()), 8'h80, 8'h7F};
            send_beat(bt, 1'b0, '0);
        end
        row = beat_row(1'b0, 16'd0, 4'h0, 32'h0);
        send_beat(row.beat, 1'b0, '0);
        row = beat_row(1'b1, 16'd0, 4'h0, 32'h0);
        send_beat(row.beat, 1'b0, '0);
        btn_state = '0;

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin
                    new_thr = '{bpd_pkg::DebounceReset, bpd_pkg::HoldReset,
                                bpd_pkg::LongReset, bpd_pkg::VlongReset};
                    tick_max = 16'hFFFF;
                end
                5: begin
                    foreach (new_thr[k])
                        new_thr[k] = $urandom_range(0, 20000);
                    tick_max = 16'd4000;
                end
                6: begin
                    new_thr = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};
                    tick_max = 16'd3000;
                end
                default: begin
                    new_thr[bpd_pkg::CFG_DEBOUNCE] = $urandom_range(0, 3000);
                    new_thr[bpd_pkg::CFG_HOLD] = new_thr[bpd_pkg::CFG_DEBOUNCE]
                                                 + $urandom_range(0, 6000);
                    new_thr[bpd_pkg::CFG_LONG] = new_thr[bpd_pkg::CFG_HOLD]
                                                 + $urandom_range(0, 10000);
                    new_thr[bpd_pkg::CFG_VLONG] = new_thr[bpd_pkg::CFG_LONG]
                                                  + $urandom_range(0, 20000);
                    tick_max = 16'd2000;
                end
            endcase
            for (int k = 0; k < 4; k++)
                write_threshold(bpd_pkg::t_cfg_idx'(k), new_thr[k]);
            set_idle(t_idle'(ph % 4));
            drain_div = (ph % 2 == 0) ? 10 : 300;
            toggle_div = $urandom_range(3, 20);
            foreach (bias[e])
                bias[e] = 2'($urandom_range(0, 2));

            repeat (120) begin
                bt = '0;
                bt.drain = ($urandom_range(0, drain_div - 1) == 0);
                case ($urandom_range(0, 19))
                    0: bt.tick_us = 16'h0000;
                    1: bt.tick_us = 16'hFFFF;
                    2: bt.tick_us = 16'($urandom());
                    default: bt.tick_us = 16'($urandom_range(0, tick_max));
                endcase
                if (bt.drain) begin
                    bt.buttons = 4'($urandom());
                    bt.steps = $urandom();
                end else begin
                    if ($urandom_range(0, 11) == 0) begin
                        // noise: jump every level at once
                        btn_state = 4'($urandom());
                    end else begin
                        for (int b = 0; b < 4; b++)
                            if ($urandom_range(0, toggle_div - 1) == 0)
                                btn_state[b] = ~btn_state[b];
                    end
                    bt.buttons = btn_state;
                    for (int e = 0; e < 4; e++) begin
                        case (bias[e])
                            2'd1: bt.steps[e] = 8'($urandom_range(64, 127));
                            2'd2: bt.steps[e] = 8'($urandom_range(128, 192));
                            default: bt.steps[e] = 8'($urandom());
                        endcase
                    end
                end
                send_beat(bt, 1'b0, '0);
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_snaps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bpd_pkg.sv
hw/rtl/bpd_cfg.sv
hw/rtl/bpd_button.sv
hw/rtl/bpd_accum.sv
hw/rtl/button_press_duration_events.sv
hw/rtl/bpd_checker.sv
tb/tb.sv
